/* rtl/vdc_pkg.sv */
// ---------------------------------------------------------------------------
// Voxel displacement covariance package
// Widths, request codes, the entry record and the arithmetic helpers of the
// per-entry mean and covariance accumulator.
// ---------------------------------------------------------------------------
package vdc_pkg;

	localparam int ENTRIES_DEF = 4096;
	localparam int ENT_BITS    = 12;
	localparam int ENT_EXT     = 17;
	localparam int CNT_BITS    = 11;
	localparam int DISP_BITS   = 16;
	localparam int SUM_BITS    = DISP_BITS + 10;
	localparam int SQ_BITS     = 2 * DISP_BITS;
	localparam int PROD_BITS   = 2 * DISP_BITS + 10;
	localparam int STAT_BITS   = 32;
	localparam int MAG_BITS    = PROD_BITS;
	localparam int DIV_STEP    = 2;
	localparam int DIV_STAGES  = MAG_BITS / DIV_STEP;
	localparam int LANES       = 9;
	localparam int MEANS       = 3;
	localparam int MOMENTS     = 6;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ACCUM = 2'd1,
		REQ_FINAL = 2'd2
	} req_t;

	typedef struct packed {
		logic signed [SUM_BITS-1:0]  sx;
		logic signed [SUM_BITS-1:0]  sy;
		logic signed [SUM_BITS-1:0]  sz;
		logic signed [PROD_BITS-1:0] qx;
		logic signed [PROD_BITS-1:0] qy;
		logic signed [PROD_BITS-1:0] qz;
		logic signed [PROD_BITS-1:0] pxy;
		logic signed [PROD_BITS-1:0] pxz;
		logic signed [PROD_BITS-1:0] pyz;
	} acc_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] rem;
		logic [MAG_BITS-1:0] w;
	} div_t;

	// Restoring division, DIV_STEP quotient bits. The dividend shifts out of
	// the top of w while quotient bits enter at the bottom.
	function automatic div_t div_step(div_t d, logic [CNT_BITS-1:0] n);
		logic [CNT_BITS:0] t;
		div_t r;
		r = d;
		for (int i = 0; i < DIV_STEP; i++) begin
			t = {r.rem, r.w[MAG_BITS-1]};
			r.w = {r.w[MAG_BITS-2:0], 1'b0};
			if (t >= {1'b0, n}) begin
				t = t - {1'b0, n};
				r.w[0] = 1'b1;
			end
			r.rem = t[CNT_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SUM_BITS-1:0] sat_sum(logic signed [SUM_BITS:0] v);
		logic signed [SUM_BITS-1:0] r;
		if (v[SUM_BITS] != v[SUM_BITS-1])
			r = v[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
		else
			r = v[SUM_BITS-1:0];
		return r;
	endfunction

	function automatic logic signed [PROD_BITS-1:0] sat_prod(logic signed [PROD_BITS:0] v);
		logic signed [PROD_BITS-1:0] r;
		if (v[PROD_BITS] != v[PROD_BITS-1])
			r = v[PROD_BITS] ? {1'b1, {(PROD_BITS-1){1'b0}}} : {1'b0, {(PROD_BITS-1){1'b1}}};
		else
			r = v[PROD_BITS-1:0];
		return r;
	endfunction

	function automatic logic signed [DISP_BITS-1:0] sat_mean(logic signed [MAG_BITS:0] v);
		logic signed [DISP_BITS-1:0] r;
		if (v > (MAG_BITS+1)'(32'sd32767))
			r = {1'b0, {(DISP_BITS-1){1'b1}}};
		else if (v < (MAG_BITS+1)'(-32'sd32768))
			r = {1'b1, {(DISP_BITS-1){1'b0}}};
		else
			r = v[DISP_BITS-1:0];
		return r;
	endfunction

	function automatic logic signed [STAT_BITS-1:0] sat_stat(logic signed [MAG_BITS+1:0] v);
		logic signed [STAT_BITS-1:0] r;
		if (v > (MAG_BITS+2)'(64'sd2147483647))
			r = {1'b0, {(STAT_BITS-1){1'b1}}};
		else if (v < (MAG_BITS+2)'(-64'sd2147483648))
			r = {1'b1, {(STAT_BITS-1){1'b0}}};
		else
			r = v[STAT_BITS-1:0];
		return r;
	endfunction

endpackage

/* rtl/voxel_displacement_covariance_core.sv */
// ---------------------------------------------------------------------------
// Voxel displacement covariance core
// Per-entry running sums of a 3D displacement, its squares and cross products,
// with clear, accumulate and finalize requests; finalize emits means and the
// covariance terms.
// ---------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_*      in         requests: tuser = req_type, tdata = entry, disp_x/y/z
//  m_*      out        statistics of one entry per finalize request
//  p*       in/out     register subject_count at byte address 0
//
// One request enters per cycle unless the output stalls; a finalize result
// leaves after its request passes through the stages of read, multiply and
// read-modify-write, one load and 21 stages of the two-bit-per-stage
// divider, then sign fixup, mean products and subtraction. Read-modify-write
// hazards are resolved by bypassing the last two writes. The whole pipeline
// stalls together while a result waits at the output. Reset clears the valid
// bits and sets subject_count to 1; the entry memory is not cleared.
module voxel_displacement_covariance_core #(
	parameter int ENTRIES = vdc_pkg::ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// entry[11:0], disp_x[27:12], disp_y[43:28], disp_z[59:44], zeros above
	input  logic [63:0]  s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// entry_out[11:0], mean_x[27:12], mean_y[43:28], mean_z[59:44],
	// var_x[91:60], var_y[123:92], var_z[155:124], cov_xy[187:156],
	// cov_xz[219:188], cov_yz[251:220], zeros above
	output logic [255:0] m_tdata
);

	localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int DB  = vdc_pkg::DISP_BITS;
	localparam int MB  = vdc_pkg::MAG_BITS;
	localparam int SB  = vdc_pkg::STAT_BITS;
	localparam int NL  = vdc_pkg::LANES;
	localparam int NS  = vdc_pkg::DIV_STAGES;
	localparam int EB  = vdc_pkg::ENT_BITS;

	// Configuration.
	logic [vdc_pkg::CNT_BITS-1:0] sc_q;
	logic [vdc_pkg::CNT_BITS-1:0] divisor;

	// Handshake and memory.
	logic adv;
	logic accept;
	logic [vdc_pkg::ENT_EXT-1:0] in_ext;
	vdc_pkg::acc_t acc_mem_q [ENTRIES];

	// Stage 1: request and read data.
	logic                          v_s1;
	logic [1:0]                    req_s1;
	logic [EB-1:0]                 ent_s1;
	logic signed [DB-1:0]          dx_s1, dy_s1, dz_s1;
	vdc_pkg::acc_t                 rd_s1;
	logic [vdc_pkg::ENT_EXT-1:0]   ext_s1;
	logic                          ok_s1;

	// Stage 2: products and read-modify-write.
	logic                          clr_s2, add_s2, fin_s2;
	logic [EB-1:0]                 ent_s2;
	logic signed [DB-1:0]          dx_s2, dy_s2, dz_s2;
	logic signed [vdc_pkg::SQ_BITS-1:0] pxx_s2, pyy_s2, pzz_s2, pxy_s2, pxz_s2, pyz_s2;
	vdc_pkg::acc_t                 rd_s2;
	vdc_pkg::acc_t                 cur;
	vdc_pkg::acc_t                 nxt;
	logic                          wr_s2;
	logic [vdc_pkg::ENT_EXT-1:0]   ext_s2;
	logic [AW-1:0]                 addr_s2;

	// Last two writes, for bypassing.
	logic                          wb1_v_q, wb2_v_q;
	logic [AW-1:0]                 wb1_a_q, wb2_a_q;
	vdc_pkg::acc_t                 wb1_d_q, wb2_d_q;

	// Stage 3: sums of a finalize request.
	logic                          v_s3;
	logic [EB-1:0]                 ent_s3;
	vdc_pkg::acc_t                 sums_s3;
	logic signed [MB-1:0]          lane_val [NL];

	// Divider stages.
	logic                          dv_v_s  [NS+1];
	logic [EB-1:0]                 dv_e_s  [NS+1];
	logic                          dv_n_s  [NS+1][NL];
	vdc_pkg::div_t                 dv_s    [NS+1][NL];

	// Stages 5 to 7.
	logic                          v_s5, v_s6, v_s7;
	logic [EB-1:0]                 ent_s5, ent_s6, ent_s7;
	logic signed [MB:0]            quot [NL];
	logic signed [DB-1:0]          mean_s5 [vdc_pkg::MEANS];
	logic signed [DB-1:0]          mean_s6 [vdc_pkg::MEANS];
	logic signed [DB-1:0]          mean_s7 [vdc_pkg::MEANS];
	logic signed [MB:0]            mom_s5 [vdc_pkg::MOMENTS];
	logic signed [MB:0]            mom_s6 [vdc_pkg::MOMENTS];
	logic signed [vdc_pkg::SQ_BITS-1:0] mm_s6 [vdc_pkg::MOMENTS];
	logic signed [SB-1:0]          stat_s7 [vdc_pkg::MOMENTS];

	// ------------------------------------------------------------------
	// Configuration port.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32-vdc_pkg::CNT_BITS){1'b0}}, sc_q};
	assign divisor = (sc_q == '0) ? vdc_pkg::CNT_BITS'(1) : sc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= vdc_pkg::CNT_BITS'(1);
		end else if (psel && penable && pwrite && !paddr[2]) begin
			sc_q <= pwdata[vdc_pkg::CNT_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Handshake.
	// ------------------------------------------------------------------
	assign adv      = !v_s7 || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;
	assign in_ext   = {{(vdc_pkg::ENT_EXT-EB){1'b0}}, s_tdata[EB-1:0]};

	// ------------------------------------------------------------------
	// Stage 1 decode and stage 2 read-modify-write.
	// ------------------------------------------------------------------
	assign ext_s1 = {{(vdc_pkg::ENT_EXT-EB){1'b0}}, ent_s1};
	assign ok_s1  = v_s1 && (ext_s1 < vdc_pkg::ENT_EXT'(ENTRIES));
	assign ext_s2 = {{(vdc_pkg::ENT_EXT-EB){1'b0}}, ent_s2};
	assign addr_s2 = ext_s2[AW-1:0];
	assign wr_s2  = clr_s2 || add_s2;

	always_comb begin
		if (wb1_v_q && wb1_a_q == addr_s2)
			cur = wb1_d_q;
		else if (wb2_v_q && wb2_a_q == addr_s2)
			cur = wb2_d_q;
		else
			cur = rd_s2;
	end

	always_comb begin
		if (clr_s2) begin
			nxt = '0;
		end else begin
			nxt.sx  = vdc_pkg::sat_sum((vdc_pkg::SUM_BITS+1)'(cur.sx) + (vdc_pkg::SUM_BITS+1)'(dx_s2));
			nxt.sy  = vdc_pkg::sat_sum((vdc_pkg::SUM_BITS+1)'(cur.sy) + (vdc_pkg::SUM_BITS+1)'(dy_s2));
			nxt.sz  = vdc_pkg::sat_sum((vdc_pkg::SUM_BITS+1)'(cur.sz) + (vdc_pkg::SUM_BITS+1)'(dz_s2));
			nxt.qx  = vdc_pkg::sat_prod((MB+1)'(cur.qx) + (MB+1)'(pxx_s2));
			nxt.qy  = vdc_pkg::sat_prod((MB+1)'(cur.qy) + (MB+1)'(pyy_s2));
			nxt.qz  = vdc_pkg::sat_prod((MB+1)'(cur.qz) + (MB+1)'(pzz_s2));
			nxt.pxy = vdc_pkg::sat_prod((MB+1)'(cur.pxy) + (MB+1)'(pxy_s2));
			nxt.pxz = vdc_pkg::sat_prod((MB+1)'(cur.pxz) + (MB+1)'(pxz_s2));
			nxt.pyz = vdc_pkg::sat_prod((MB+1)'(cur.pyz) + (MB+1)'(pyz_s2));
		end
	end

	// Entry memory: read on acceptance, written back from stage 2.
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= acc_mem_q[in_ext[AW-1:0]];
			if (wr_s2)
				acc_mem_q[addr_s2] <= nxt;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3 lanes and stage 5 quotients.
	// ------------------------------------------------------------------
	always_comb begin
		lane_val[0] = MB'(sums_s3.sx);
		lane_val[1] = MB'(sums_s3.sy);
		lane_val[2] = MB'(sums_s3.sz);
		lane_val[3] = sums_s3.qx;
		lane_val[4] = sums_s3.qy;
		lane_val[5] = sums_s3.qz;
		lane_val[6] = sums_s3.pxy;
		lane_val[7] = sums_s3.pxz;
		lane_val[8] = sums_s3.pyz;
	end

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			if (dv_n_s[NS][l])
				quot[l] = -$signed({1'b0, dv_s[NS][l].w});
			else
				quot[l] = $signed({1'b0, dv_s[NS][l].w});
		end
	end

	// ------------------------------------------------------------------
	// Valid bits.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			clr_s2  <= 1'b0;
			add_s2  <= 1'b0;
			fin_s2  <= 1'b0;
			wb1_v_q <= 1'b0;
			wb2_v_q <= 1'b0;
			v_s3    <= 1'b0;
			for (int k = 0; k <= NS; k++)
				dv_v_s[k] <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
		end else if (adv) begin
			v_s1    <= accept;
			clr_s2  <= ok_s1 && (req_s1 == vdc_pkg::REQ_CLEAR);
			add_s2  <= ok_s1 && (req_s1 == vdc_pkg::REQ_ACCUM);
			fin_s2  <= ok_s1 && (req_s1 == vdc_pkg::REQ_FINAL);
			wb1_v_q <= wr_s2;
			wb2_v_q <= wb1_v_q;
			v_s3    <= fin_s2;
			dv_v_s[0] <= v_s3;
			for (int k = 0; k < NS; k++)
				dv_v_s[k+1] <= dv_v_s[k];
			v_s5    <= dv_v_s[NS];
			v_s6    <= v_s5;
			v_s7    <= v_s6;
		end
	end

	// ------------------------------------------------------------------
	// Payload.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= s_tuser;
			ent_s1 <= s_tdata[EB-1:0];
			dx_s1  <= s_tdata[EB+DB-1:EB];
			dy_s1  <= s_tdata[EB+2*DB-1:EB+DB];
			dz_s1  <= s_tdata[EB+3*DB-1:EB+2*DB];

			ent_s2 <= ent_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dz_s2  <= dz_s1;
			pxx_s2 <= dx_s1 * dx_s1;
			pyy_s2 <= dy_s1 * dy_s1;
			pzz_s2 <= dz_s1 * dz_s1;
			pxy_s2 <= dx_s1 * dy_s1;
			pxz_s2 <= dx_s1 * dz_s1;
			pyz_s2 <= dy_s1 * dz_s1;
			rd_s2  <= rd_s1;

			wb1_a_q <= addr_s2;
			wb1_d_q <= nxt;
			wb2_a_q <= wb1_a_q;
			wb2_d_q <= wb1_d_q;

			ent_s3  <= ent_s2;
			sums_s3 <= cur;

			// Divider load: magnitudes with their signs.
			dv_e_s[0] <= ent_s3;
			for (int l = 0; l < NL; l++) begin
				dv_n_s[0][l]   <= lane_val[l][MB-1];
				dv_s[0][l].rem <= '0;
				dv_s[0][l].w   <= lane_val[l][MB-1] ? MB'(-lane_val[l]) : MB'(lane_val[l]);
			end
			for (int k = 0; k < NS; k++) begin
				dv_e_s[k+1] <= dv_e_s[k];
				for (int l = 0; l < NL; l++) begin
					dv_n_s[k+1][l] <= dv_n_s[k][l];
					dv_s[k+1][l]   <= vdc_pkg::div_step(dv_s[k][l], divisor);
				end
			end

			ent_s5 <= dv_e_s[NS];
			for (int m = 0; m < vdc_pkg::MEANS; m++)
				mean_s5[m] <= vdc_pkg::sat_mean(quot[m]);
			for (int j = 0; j < vdc_pkg::MOMENTS; j++)
				mom_s5[j] <= quot[j+vdc_pkg::MEANS];

			ent_s6  <= ent_s5;
			mean_s6 <= mean_s5;
			mom_s6  <= mom_s5;
			mm_s6[0] <= mean_s5[0] * mean_s5[0];
			mm_s6[1] <= mean_s5[1] * mean_s5[1];
			mm_s6[2] <= mean_s5[2] * mean_s5[2];
			mm_s6[3] <= mean_s5[0] * mean_s5[1];
			mm_s6[4] <= mean_s5[0] * mean_s5[2];
			mm_s6[5] <= mean_s5[1] * mean_s5[2];

			ent_s7  <= ent_s6;
			mean_s7 <= mean_s6;
			for (int j = 0; j < vdc_pkg::MOMENTS; j++)
				stat_s7[j] <= vdc_pkg::sat_stat((MB+2)'(mom_s6[j]) - (MB+2)'(mm_s6[j]));
		end
	end

	// ------------------------------------------------------------------
	// Output.
	// ------------------------------------------------------------------
	assign m_tvalid = v_s7;
	assign m_tdata  = {4'd0, stat_s7[5], stat_s7[4], stat_s7[3], stat_s7[2], stat_s7[1],
		stat_s7[0], mean_s7[2], mean_s7[1], mean_s7[0], ent_s7};

endmodule
